/* rtl/core/stream_pattern_replace_unit_defines.svh */
// ---------------------------------------------------------------------------
// Stream pattern replace: assertion macros
// Shared property shorthands for the port checker.
// ---------------------------------------------------------------------------
`ifndef STREAM_PATTERN_REPLACE_UNIT_DEFINES_SVH
`define STREAM_PATTERN_REPLACE_UNIT_DEFINES_SVH

// next-cycle implication, switched off while in reset
`define SPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spr port check failed");

// next-cycle implication that also holds across reset
`define SPR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("spr port check failed");

`endif

/* rtl/core/spr_pkg.sv */
// ---------------------------------------------------------------------------
// Stream pattern replace: package
// Shared constants, register codes, command word and byte select.
// ---------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

  localparam int STORE_BYTES      = 16;
  localparam int STORE_BITS       = 8 * STORE_BYTES;
  localparam int BYTE_IDX_W       = 4;
  localparam int LEN_W            = 5;
  localparam int CNT_W            = 7;
  localparam int COUNTER_MAX      = 127;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 64;
  localparam int MAX_PATTERN_DEF  = 16;
  localparam int SELECT_BITS_DEF  = 64;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = 1;
  localparam int QCNT_W           = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_REPLACE_LOW  = 3'd3,
    REG_REPLACE_HIGH = 3'd4,
    REG_REPLACE_LEN  = 3'd5,
    REG_SELECT_EN    = 3'd6,
    REG_SELECT_MASK  = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    CMD_PREFIX,
    CMD_REPLACE
  } cmd_kind_t;

  // one run of output words; len counts the tail byte when present
  typedef struct packed {
    cmd_kind_t        kind;
    logic [LEN_W-1:0] len;
    logic             tail_valid;
    logic [7:0]       tail_byte;
  } cmd_t;

  function automatic logic [7:0] byte_sel(input logic [STORE_BITS-1:0] v,
                                          input logic [BYTE_IDX_W-1:0] i);
    return v[{i, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/spr_in_if.sv */
// ---------------------------------------------------------------------------
// Stream pattern replace: input channel
// Valid/ready channel carrying one stream byte or an end-of-stream mark.
// ---------------------------------------------------------------------------
`default_nettype none

interface spr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

`default_nettype wire

/* rtl/core/spr_out_if.sv */
// ---------------------------------------------------------------------------
// Stream pattern replace: output channel
// Valid/ready channel carrying one rewritten byte with its flags.
// ---------------------------------------------------------------------------
`default_nettype none

interface spr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       from_replacement;
  logic       last_of_run;

  modport source (output valid, out_byte, from_replacement, last_of_run, input ready);
  modport sink   (input valid, out_byte, from_replacement, last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/core/spr_front.sv */
// ---------------------------------------------------------------------------
// Stream pattern replace: front end
// Accepts words, tracks the match position and counter, queues run commands.
// ---------------------------------------------------------------------------
`default_nettype none

module spr_front #(
  parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEF,
  parameter int SELECT_BITS = spr_pkg::SELECT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  spr_in_if.sink                           stream,
  input  wire logic [spr_pkg::STORE_BITS-1:0] pattern_bytes,
  input  wire logic [spr_pkg::LEN_W-1:0]   pattern_len,
  input  wire logic [spr_pkg::LEN_W-1:0]   replace_len,
  input  wire logic                        select_enable,
  input  wire logic [SELECT_BITS-1:0]      select_mask,
  input  wire logic                        clear_position,
  input  wire logic                        queue_full,
  output spr_pkg::cmd_t                    push_cmd,
  output logic                             push_valid
);
  import spr_pkg::*;

  localparam int PAT_BYTES = (MAX_PATTERN < STORE_BYTES) ? MAX_PATTERN : STORE_BYTES;

  logic [LEN_W-1:0] match_position, match_position_next;
  logic [CNT_W-1:0] match_counter, match_counter_next;
  logic [LEN_W-1:0] plen, pos, rlen;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       pbyte;
  logic             accept, hit, chosen;

  assign stream.ready = !queue_full;
  assign accept       = stream.valid && !queue_full;

  always_comb begin
    if (pattern_len == '0) begin
      plen = LEN_W'(1);
    end else if (pattern_len > LEN_W'(PAT_BYTES)) begin
      plen = LEN_W'(PAT_BYTES);
    end else begin
      plen = pattern_len;
    end
    rlen      = (replace_len > LEN_W'(STORE_BYTES)) ? LEN_W'(STORE_BYTES) : replace_len;
    pos       = (match_position >= plen) ? '0 : match_position;
    pbyte     = byte_sel(pattern_bytes, pos[BYTE_IDX_W-1:0]);
    count_inc = (match_counter != CNT_W'(COUNTER_MAX)) ? match_counter + CNT_W'(1)
                                                       : match_counter;
    // numbers above the mask width never hit; with selection on they are never chosen
    hit = 1'b0;
    for (int k = 0; k < SELECT_BITS; k++) begin
      if (count_inc == CNT_W'(k + 1)) hit = select_mask[k];
    end
    chosen = !select_enable || hit;

    match_position_next = pos;
    match_counter_next  = match_counter;
    push_valid          = 1'b0;
    push_cmd            = '0;
    push_cmd.kind       = CMD_PREFIX;

    if (accept) begin
      if (stream.end_of_stream) begin
        match_position_next = '0;
        if (pos != '0) begin
          push_valid   = 1'b1;
          push_cmd.len = pos;
        end
      end else if (stream.data_byte == pbyte) begin
        if (pos + LEN_W'(1) >= plen) begin
          match_position_next = '0;
          match_counter_next  = count_inc;
          if (chosen) begin
            if (rlen != '0) begin
              push_valid    = 1'b1;
              push_cmd.kind = CMD_REPLACE;
              push_cmd.len  = rlen;
            end
          end else begin
            push_valid   = 1'b1;
            push_cmd.len = plen;
          end
        end else begin
          match_position_next = pos + LEN_W'(1);
        end
      end else begin
        match_position_next = '0;
        push_valid          = 1'b1;
        push_cmd.len        = pos + LEN_W'(1);
        push_cmd.tail_valid = 1'b1;
        push_cmd.tail_byte  = stream.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_position <= '0;
      match_counter  <= '0;
    end else begin
      match_counter <= match_counter_next;
      if (clear_position) begin
        match_position <= '0;
      end else begin
        match_position <= match_position_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/spr_queue.sv */
// ---------------------------------------------------------------------------
// Stream pattern replace: command queue
// Two-entry FIFO decoupling the front end from the output sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module spr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire spr_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output spr_pkg::cmd_t      head_cmd
);
  import spr_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/spr_back.sv */
// ---------------------------------------------------------------------------
// Stream pattern replace: output sequencer
// Expands queued run commands into output words, one per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module spr_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           head_valid,
  input  wire spr_pkg::cmd_t                  head_cmd,
  output logic                                pop,
  input  wire logic [spr_pkg::STORE_BITS-1:0] pattern_bytes,
  input  wire logic [spr_pkg::STORE_BITS-1:0] replace_bytes,
  spr_out_if.source                           rewrite
);
  import spr_pkg::*;

  logic                  busy;
  cmd_t                  cmd;
  logic [BYTE_IDX_W-1:0] idx;
  logic                  slot_free, emit, last;
  logic [7:0]            word_byte;
  logic                  word_rep;

  assign slot_free = !rewrite.valid || rewrite.ready;
  assign emit      = busy && slot_free;
  assign last      = ({1'b0, idx} == cmd.len - LEN_W'(1));
  assign pop       = head_valid && (!busy || (emit && last));

  always_comb begin
    if (cmd.kind == CMD_REPLACE) begin
      word_byte = byte_sel(replace_bytes, idx);
      word_rep  = 1'b1;
    end else if (cmd.tail_valid && last) begin
      word_byte = cmd.tail_byte;
      word_rep  = 1'b0;
    end else begin
      word_byte = byte_sel(pattern_bytes, idx);
      word_rep  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rewrite.out_byte         <= word_byte;
      rewrite.from_replacement <= word_rep;
      rewrite.last_of_run      <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      rewrite.valid <= 1'b0;
    end else begin
      if (emit) begin
        rewrite.valid <= 1'b1;
      end else if (rewrite.ready) begin
        rewrite.valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head_cmd;
      idx <= '0;
    end else if (emit) begin
      idx <= idx + BYTE_IDX_W'(1);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stream_pattern_replace_unit.sv */
// A run's first word passes the command queue, the output sequencer's command
// register and the output register before it is valid; a word that gives N output
// words occupies the output sequencer until all N have been emitted.
// Input ready falls only while the two-entry command queue is full.
// Reset (rst, synchronous): control and configuration registers to their reset values, queue and output empty.
// ---------------------------------------------------------------------------
// Stream pattern replace unit
// Byte stream search and replace with a 16-byte pattern, a 16-byte replacement
// and per-match selection through a mask.
// ---------------------------------------------------------------------------
`default_nettype none

module stream_pattern_replace_unit #(
  parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEF,
  parameter int SELECT_BITS = spr_pkg::SELECT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  spr_in_if.sink                             stream,
  spr_out_if.source                          rewrite,
  input  wire logic                          cfg_we,
  input  wire logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [spr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spr_pkg::*;

  // Pattern bytes past the usable length are never read, so only those that
  // can be compared are stored.
  localparam int PAT_BYTES = (MAX_PATTERN < STORE_BYTES) ? MAX_PATTERN : STORE_BYTES;

  // configuration registers
  logic [8*PAT_BYTES-1:0] pattern;
  logic [LEN_W-1:0]       pattern_len;
  logic [CFG_DATA_W-1:0]  replace_low, replace_high;
  logic [LEN_W-1:0]       replace_len;
  logic                   select_enable;
  logic [SELECT_BITS-1:0] select_mask;

  logic [STORE_BITS-1:0]  pattern_bytes, replace_bytes;
  logic                   clear_position;

  // front/queue/back hand-off
  cmd_t push_cmd, head_cmd;
  logic push_valid, queue_full, head_valid, pop;

  assign pattern_bytes  = STORE_BITS'(pattern);
  assign replace_bytes  = {replace_high, replace_low};
  // a new pattern length drops any held prefix
  assign clear_position = cfg_we && (cfg_index == REG_PATTERN_LEN);

  // Register writes. Pattern bytes 0..7 come from the low word, 8..15 from
  // the high word; each stored byte picks its own source.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern       <= '0;
      pattern_len   <= LEN_W'(1);
      replace_low   <= '0;
      replace_high  <= '0;
      replace_len   <= '0;
      select_enable <= 1'b0;
      select_mask   <= '0;
    end else if (cfg_we) begin
      for (int j = 0; j < PAT_BYTES; j++) begin
        if ((j < 8) && (cfg_index == REG_PATTERN_LOW)) begin
          pattern[8*j +: 8] <= cfg_data[8*(j%8) +: 8];
        end
        if ((j >= 8) && (cfg_index == REG_PATTERN_HIGH)) begin
          pattern[8*j +: 8] <= cfg_data[8*(j%8) +: 8];
        end
      end
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LEN:  pattern_len   <= cfg_data[LEN_W-1:0];
        REG_REPLACE_LOW:  replace_low   <= cfg_data;
        REG_REPLACE_HIGH: replace_high  <= cfg_data;
        REG_REPLACE_LEN:  replace_len   <= cfg_data[LEN_W-1:0];
        REG_SELECT_EN:    select_enable <= cfg_data[0];
        REG_SELECT_MASK:  select_mask   <= cfg_data[SELECT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front end: match tracking and run classification, one word per cycle while the queue is not full.
  spr_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .SELECT_BITS (SELECT_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .stream         (stream),
    .pattern_bytes  (pattern_bytes),
    .pattern_len    (pattern_len),
    .replace_len    (replace_len),
    .select_enable  (select_enable),
    .select_mask    (select_mask),
    .clear_position (clear_position),
    .queue_full     (queue_full),
    .push_cmd       (push_cmd),
    .push_valid     (push_valid)
  );

  // Short command queue so input and output stall independently.
  spr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: expands each run into words behind a registered output stage.
  spr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_cmd      (head_cmd),
    .pop           (pop),
    .pattern_bytes (pattern_bytes),
    .replace_bytes (replace_bytes),
    .rewrite       (rewrite)
  );

endmodule

`default_nettype wire

/* rtl/core/spr_checker.sv */
// ---------------------------------------------------------------------------
// Stream pattern replace: port checker
// Watches the output channel of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stream_pattern_replace_unit_defines.svh"

module spr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       from_replacement,
  input wire logic       last_of_run
);

  // stalled word stays offered
  `SPR_ASSERT_NEXT(a_valid_held, clk, rst, out_valid && !out_ready, out_valid)

  // stalled word does not change
  `SPR_ASSERT_NEXT(a_word_held, clk, rst, out_valid && !out_ready, $stable(out_byte) && $stable(from_replacement) && $stable(last_of_run))

  // a run goes out without gaps and keeps its source
  `SPR_ASSERT_NEXT(a_run_contiguous, clk, rst, out_valid && out_ready && !last_of_run, out_valid && (from_replacement == $past(from_replacement)))

  // reset empties the output stage
  `SPR_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind stream_pattern_replace_unit spr_checker u_spr_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (rewrite.valid),
  .out_ready        (rewrite.ready),
  .out_byte         (rewrite.out_byte),
  .from_replacement (rewrite.from_replacement),
  .last_of_run      (rewrite.last_of_run)
);

`default_nettype wire
